// ===== hw/rtl/prp_pkg.sv =====
// ----------------------------------------------------------------------------
// prp_pkg
// shared types, codes and helper functions of the peer registry
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam logic [3:0] KIND_BEACON     = 4'd0;
  localparam logic [3:0] KIND_BEACON_ACK = 4'd1;
  localparam logic [3:0] KIND_PAIR_REQ   = 4'd2;
  localparam logic [3:0] KIND_PAIR_ACK   = 4'd3;
  localparam logic [3:0] KIND_OTHER      = 4'd4;
  localparam logic [3:0] KIND_RESTORE    = 4'd5;
  localparam logic [3:0] KIND_FORGET     = 4'd6;
  localparam logic [3:0] KIND_FORGET_ALL = 4'd7;
  localparam logic [3:0] KIND_LOOKUP     = 4'd8;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
  localparam logic [1:0] STATUS_REJECTED = 2'd3;

  localparam logic [1:0] ST_ONLINE  = 2'd0;
  localparam logic [1:0] ST_STALE   = 2'd1;
  localparam logic [1:0] ST_OFFLINE = 2'd2;

  localparam logic [3:0] ROLE_START     = 4'd1;
  localparam logic [3:0] ROLE_FINISH    = 4'd2;
  localparam logic [3:0] ROLE_SPEEDTRAP = 4'd3;
  localparam logic [3:0] ROLE_TELEMETRY = 4'd4;

  localparam logic [1:0] REG_MY_ROLE      = 2'd0;
  localparam logic [1:0] REG_ONLINE_LIMIT = 2'd1;
  localparam logic [1:0] REG_STALE_LIMIT  = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [47:0] src_mac;
    logic [3:0]  peer_role;
    logic [7:0]  dev_code;
    logic [31:0] now_ms;
    logic        restore_paired;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  entry_index;
    logic [1:0]  entry_state;
    logic [47:0] found_mac;
    logic        send_beacon_ack;
    logic        send_pair_request;
    logic        send_pair_ack;
    logic        save_request;
    logic        evicted;
    logic        any_online;
  } result_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [3:0]  role;
    logic [7:0]  device;
    logic [31:0] last_seen;
    logic        paired;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic set_paired;
    logic touch;
  } cell_ctrl_t;

  function automatic logic is_client(input logic [3:0] r);
    return r == ROLE_START || r == ROLE_SPEEDTRAP || r == ROLE_TELEMETRY;
  endfunction

  function automatic logic compatible(input logic [3:0] mine, input logic [3:0] theirs);
    if (mine == ROLE_FINISH) return is_client(theirs);
    if (theirs == ROLE_FINISH) return is_client(mine);
    return 1'b0;
  endfunction

  function automatic logic [1:0] state_of(input logic [31:0] last, input logic [31:0] now,
                                          input logic [31:0] on_lim,
                                          input logic [31:0] stale_lim);
    logic [31:0] age;
    age = now - last;
    if (last == 32'd0) return ST_OFFLINE;
    if (age < on_lim) return ST_ONLINE;
    if (age < stale_lim) return ST_STALE;
    return ST_OFFLINE;
  endfunction

endpackage

// ===== hw/rtl/peer_registry_with_pairing.sv =====
// ----------------------------------------------------------------------------
// peer_registry_with_pairing
// compacted peer table with upsert, eviction, restore, forget, lookup and role-aware pairing
// ----------------------------------------------------------------------------
// One item is handled at a time: a walk over the row of cells gathers matches,
// eviction candidates and lookup hits, the decide step updates the row (shifts
// run along the chain in the same cycle), and a second walk forms the online
// summary. The result stays registered until taken and the next item is
// accepted in the cycle after it is taken; configuration must be written while
// no transaction is in flight.
module peer_registry_with_pairing #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  prp_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output prp_pkg::result_t  result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import prp_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_ONL    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state;
  logic [3:0]    my_role;
  logic [31:0]   online_limit;
  logic [31:0]   stale_limit;
  item_t         item_q;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] pos;
  result_t       res;

  logic          hit, unp_ok, off_ok, lk1_ok, lk2_ok;
  logic [IW-1:0] hit_idx, unp_idx, off_idx, lk1_idx, lk2_idx;
  logic          hit_paired;
  logic [1:0]    hit_st, lk1_st, lk2_st;
  logic [31:0]   unp_last, off_last;
  logic [47:0]   lk1_mac, lk2_mac;

  entry_t        cells_q [TABLE_DEPTH];
  cell_ctrl_t    cctrl [TABLE_DEPTH];
  entry_t        cur;
  logic [1:0]    cur_st;
  logic          scan_end;

  // decision signals
  logic          wr, shift, setp, touch;
  logic [IW-1:0] wpos, spos;
  entry_t        newe;
  result_t       dres;
  logic          up_ok, up_new, up_ev;
  logic [IW-1:0] up_idx, up_v;
  logic [1:0]    fst;
  logic          full;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_role      <= 4'd0;
      online_limit <= 32'd15000;
      stale_limit  <= 32'd60000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MY_ROLE:      my_role <= cfg_data[3:0];
        REG_ONLINE_LIMIT: online_limit <= cfg_data;
        REG_STALE_LIMIT:  stale_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cells_q[i+1];
    end
    always_comb begin
      cctrl[i].load       = (state == S_DECIDE) && wr && (wpos == IW'(i));
      cctrl[i].shift      = (state == S_DECIDE) && shift && (IW'(i) >= spos) &&
                            (CW'(i + 1) < count);
      cctrl[i].set_paired = (state == S_DECIDE) && setp && (hit_idx == IW'(i));
      cctrl[i].touch      = (state == S_DECIDE) && touch && (hit_idx == IW'(i));
    end
    prp_cell u_cell (
      .clk  (clk),
      .ctrl (cctrl[i]),
      .din  (newe),
      .nbr  (nbr),
      .q    (cells_q[i])
    );
  end

  assign cur      = cells_q[pos[IW-1:0]];
  assign cur_st   = state_of(cur.last_seen, item_q.now_ms, online_limit, stale_limit);
  assign scan_end = (pos == count);
  assign fst      = state_of(item_q.now_ms, item_q.now_ms, online_limit, stale_limit);
  assign full     = (count == CW'(TABLE_DEPTH));

  // upsert placement
  always_comb begin
    up_ok  = 1'b1;
    up_new = 1'b0;
    up_ev  = 1'b0;
    up_idx = hit_idx;
    up_v   = unp_ok ? unp_idx : off_idx;
    if (!hit) begin
      up_new = 1'b1;
      if (!full) begin
        up_idx = count[IW-1:0];
      end else if (unp_ok || off_ok) begin
        up_ev  = 1'b1;
        up_idx = IW'(TABLE_DEPTH - 1);
      end else begin
        up_ok = 1'b0;
      end
    end
  end

  always_comb begin
    wr         = 1'b0;
    shift      = 1'b0;
    setp       = 1'b0;
    touch      = 1'b0;
    wpos       = up_idx;
    spos       = up_v;
    newe       = '{mac: item_q.src_mac, role: item_q.peer_role,
                   device: item_q.dev_code, last_seen: item_q.now_ms,
                   paired: 1'b0};
    count_next = count;
    dres       = '0;
    case (item_q.kind) inside
      KIND_BEACON, KIND_BEACON_ACK, KIND_PAIR_REQ: begin
        if (item_q.kind == KIND_PAIR_REQ && !compatible(my_role, item_q.peer_role)) begin
          dres.status = STATUS_REJECTED;
        end else if (!up_ok) begin
          dres.status = STATUS_FULL;
        end else begin
          wr          = 1'b1;
          shift       = up_ev;
          newe.paired = (item_q.kind == KIND_PAIR_REQ) || (hit && hit_paired);
          if (up_new && !up_ev) count_next = count + CW'(1);
          dres.entry_index = 3'(up_idx);
          dres.entry_state = fst;
          dres.evicted     = up_ev;
          if (item_q.kind == KIND_PAIR_REQ) begin
            dres.send_pair_ack = 1'b1;
            dres.save_request  = 1'b1;
          end else begin
            dres.send_beacon_ack   = (item_q.kind == KIND_BEACON);
            dres.send_pair_request = !(hit && hit_paired) &&
                                     compatible(my_role, item_q.peer_role);
          end
        end
      end
      KIND_PAIR_ACK: begin
        if (hit) begin
          setp              = !hit_paired;
          dres.save_request = !hit_paired;
          dres.entry_index  = 3'(hit_idx);
          dres.entry_state  = hit_st;
        end else if (!up_ok) begin
          dres.status = STATUS_FULL;
        end else begin
          wr          = 1'b1;
          shift       = up_ev;
          newe.paired = 1'b1;
          if (!up_ev) count_next = count + CW'(1);
          dres.entry_index  = 3'(up_idx);
          dres.entry_state  = fst;
          dres.evicted      = up_ev;
          dres.save_request = 1'b1;
        end
      end
      KIND_OTHER: begin
        if (hit) begin
          touch            = 1'b1;
          dres.entry_index = 3'(hit_idx);
          dres.entry_state = fst;
        end else begin
          dres.status = STATUS_NOTFOUND;
        end
      end
      KIND_RESTORE: begin
        if (full) begin
          dres.status = STATUS_FULL;
        end else begin
          wr               = 1'b1;
          wpos             = count[IW-1:0];
          newe.last_seen   = 32'd0;
          newe.paired      = item_q.restore_paired;
          count_next       = count + CW'(1);
          dres.entry_index = 3'(count[IW-1:0]);
          dres.entry_state = ST_OFFLINE;
        end
      end
      KIND_FORGET: begin
        if (hit) begin
          shift             = 1'b1;
          spos              = hit_idx;
          count_next        = count - CW'(1);
          dres.entry_index  = 3'(hit_idx);
          dres.entry_state  = hit_st;
          dres.save_request = 1'b1;
        end else begin
          dres.status = STATUS_NOTFOUND;
        end
      end
      KIND_FORGET_ALL: begin
        count_next        = '0;
        dres.save_request = 1'b1;
      end
      KIND_LOOKUP: begin
        if (lk1_ok) begin
          dres.entry_index = 3'(lk1_idx);
          dres.entry_state = lk1_st;
          dres.found_mac   = lk1_mac;
        end else if (lk2_ok) begin
          dres.entry_index = 3'(lk2_idx);
          dres.entry_state = lk2_st;
          dres.found_mac   = lk2_mac;
        end else begin
          dres.status = STATUS_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pos   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_q <= item;
            pos    <= '0;
            hit    <= 1'b0;
            unp_ok <= 1'b0;
            off_ok <= 1'b0;
            lk1_ok <= 1'b0;
            lk2_ok <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_DECIDE;
          end else begin
            pos <= pos + CW'(1);
            if (!hit && cur.mac == item_q.src_mac) begin
              hit        <= 1'b1;
              hit_idx    <= pos[IW-1:0];
              hit_paired <= cur.paired;
              hit_st     <= cur_st;
            end
            if (!cur.paired && (!unp_ok || cur.last_seen < unp_last)) begin
              unp_ok   <= 1'b1;
              unp_idx  <= pos[IW-1:0];
              unp_last <= cur.last_seen;
            end
            if (cur_st == ST_OFFLINE && (!off_ok || cur.last_seen < off_last)) begin
              off_ok   <= 1'b1;
              off_idx  <= pos[IW-1:0];
              off_last <= cur.last_seen;
            end
            if (cur.paired && cur.role == item_q.peer_role) begin
              if (!lk1_ok && cur_st != ST_OFFLINE) begin
                lk1_ok  <= 1'b1;
                lk1_idx <= pos[IW-1:0];
                lk1_st  <= cur_st;
                lk1_mac <= cur.mac;
              end
              if (!lk2_ok) begin
                lk2_ok  <= 1'b1;
                lk2_idx <= pos[IW-1:0];
                lk2_st  <= cur_st;
                lk2_mac <= cur.mac;
              end
            end
          end
        end
        S_DECIDE: begin
          res   <= dres;
          count <= count_next;
          pos   <= '0;
          state <= S_ONL;
        end
        S_ONL: begin
          if (scan_end) begin
            state <= S_DONE;
          end else begin
            pos <= pos + CW'(1);
            if (cur.paired && cur_st == ST_ONLINE) res.any_online <= 1'b1;
          end
        end
        S_DONE: begin
          if (!result_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item_stall   = (state != S_IDLE);
  assign result_valid = (state == S_DONE);
  assign result       = res;

endmodule

// ===== hw/rtl/prp_cell.sv =====
// ----------------------------------------------------------------------------
// prp_cell
// one table slot: loads a new entry, takes its upper neighbour on a shift
// down, or updates the paired flag or last-seen time in place
// ----------------------------------------------------------------------------
module prp_cell (
  input  logic               clk,
  input  prp_pkg::cell_ctrl_t ctrl,
  input  prp_pkg::entry_t    din,
  input  prp_pkg::entry_t    nbr,
  output prp_pkg::entry_t    q
);
  import prp_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= din;
    end else if (ctrl.shift) begin
      q <= nbr;
    end else begin
      if (ctrl.set_paired) q.paired <= 1'b1;
      if (ctrl.touch) q.last_seen <= din.last_seen;
    end
  end

endmodule
